@@ sv/olad_pkg.sv @@
package olad_pkg;

  // Operation codes carried by opcode_i
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_READ
  } state_e;

  // Fixed field widths
  localparam int ValueW = 32;
  localparam int PosW   = 8;
  localparam int OutCntW = 5;

  // Commands from controller to datapath
  typedef struct packed {
    logic    latch;      // capture the incoming item
    logic    append;     // write tail entry, bump count
    logic    del_start;  // set index to position - 1, fetch entry at position
    logic    shift;      // move fetched entry down one slot, fetch the next
    logic    del_done;   // drop one from the count
    logic    rd_start;   // fetch the head entry
    logic    rd_step;    // fetch the next entry
    logic    out_load;   // load the result register
    logic    out_elem;   // result carries a list element
    status_e out_status;
    logic    out_last;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_e  op;
    logic full;
    logic bad_pos;
    logic empty;
    logic shift_more;
    logic rd_last;
    logic out_free;
  } stat_t;

endpackage

@@ sv/olad_ram.sv @@
module olad_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/olad_ctrl.sv @@
module olad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  olad_pkg::stat_t   stat_i,
  output olad_pkg::cmd_t    cmd_o
);

  olad_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olad_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_status = olad_pkg::ST_OK;
    in_ready_o = 1'b0;
    unique case (state_q)
      olad_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = olad_pkg::S_EXEC;
        end
      end
      olad_pkg::S_EXEC: begin
        unique case (stat_i.op)
          olad_pkg::OP_DELETE: begin
            if (stat_i.bad_pos) begin
              if (stat_i.out_free) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = olad_pkg::ST_BADPOS;
                cmd_o.out_last   = 1'b1;
                state_d          = olad_pkg::S_IDLE;
              end
            end else begin
              cmd_o.del_start = 1'b1;
              state_d         = olad_pkg::S_SHIFT;
            end
          end
          olad_pkg::OP_READ: begin
            if (stat_i.empty) begin
              if (stat_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_last = 1'b1;
                state_d        = olad_pkg::S_IDLE;
              end
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = olad_pkg::S_READ;
            end
          end
          olad_pkg::OP_APPEND: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = olad_pkg::ST_FULL;
              end else begin
                cmd_o.append = 1'b1;
              end
              state_d = olad_pkg::S_IDLE;
            end
          end
          olad_pkg::OP_COUNT: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              state_d        = olad_pkg::S_IDLE;
            end
          end
          default: ;
        endcase
      end
      olad_pkg::S_SHIFT: begin
        // Close the gap one entry per cycle, then report
        if (stat_i.shift_more) begin
          cmd_o.shift = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.del_done = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          state_d        = olad_pkg::S_IDLE;
        end
      end
      olad_pkg::S_READ: begin
        // Emit one element per free output slot
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_elem = 1'b1;
          cmd_o.out_last = stat_i.rd_last;
          if (stat_i.rd_last) begin
            state_d = olad_pkg::S_IDLE;
          end else begin
            cmd_o.rd_step = 1'b1;
          end
        end
      end
      default: state_d = olad_pkg::S_IDLE;
    endcase
  end

endmodule

@@ sv/olad_dp.sv @@
module olad_dp #(
  parameter int Depth = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  olad_pkg::cmd_t                  cmd_i,
  output olad_pkg::stat_t                 stat_o,
  input  logic [1:0]                      opcode_i,
  input  logic signed [olad_pkg::ValueW-1:0] item_value_i,
  input  logic [olad_pkg::PosW-1:0]       position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [olad_pkg::ValueW-1:0] element_value_o,
  output logic                            has_value_o,
  output logic [olad_pkg::OutCntW-1:0]    element_count_o,
  output logic [1:0]                      status_o,
  output logic                            last_o
);

  localparam int CntW  = $clog2(Depth + 1);
  localparam int AddrW = $clog2(Depth);

  olad_pkg::op_e               op_q;
  logic [olad_pkg::ValueW-1:0] val_q;
  logic [olad_pkg::PosW-1:0]   pos_q;
  logic [CntW-1:0]             len_q, len_d;
  logic [AddrW-1:0]            idx_q, idx_d;
  logic [CntW-1:0]             idx_nx;

  logic                        we, re;
  logic [AddrW-1:0]            waddr, raddr;
  logic [olad_pkg::ValueW-1:0] wdata, rdata;

  logic                        out_valid_q;
  logic [olad_pkg::ValueW-1:0] out_value_q;
  logic                        out_has_q;
  logic [olad_pkg::OutCntW-1:0] out_cnt_q;
  olad_pkg::status_e           out_status_q;
  logic                        out_last_q;

  // Capture the incoming item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= olad_pkg::op_e'(opcode_i);
      val_q <= item_value_i;
      pos_q <= position_i;
    end
  end

  assign idx_nx = CntW'(idx_q) + CntW'(1);

  // Next count and index
  always_comb begin
    len_d = len_q;
    if (cmd_i.append) begin
      len_d = len_q + CntW'(1);
    end else if (cmd_i.del_done) begin
      len_d = len_q - CntW'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    priority if (cmd_i.del_start) begin
      idx_d = AddrW'(pos_q - olad_pkg::PosW'(1));
    end else if (cmd_i.shift || cmd_i.rd_step) begin
      idx_d = AddrW'(idx_nx);
    end else if (cmd_i.rd_start) begin
      idx_d = '0;
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      idx_q <= '0;
    end else begin
      len_q <= len_d;
      idx_q <= idx_d;
    end
  end

  // Memory port steering
  assign we    = cmd_i.append | cmd_i.shift;
  assign waddr = cmd_i.append ? AddrW'(len_q) : idx_q;
  assign wdata = cmd_i.append ? val_q : rdata;
  assign re    = cmd_i.del_start | cmd_i.shift | cmd_i.rd_start | cmd_i.rd_step;

  always_comb begin
    raddr = '0;
    priority if (cmd_i.del_start) begin
      raddr = AddrW'(pos_q);
    end else if (cmd_i.shift) begin
      raddr = AddrW'(CntW'(idx_q) + CntW'(2));
    end else if (cmd_i.rd_step) begin
      raddr = AddrW'(idx_nx);
    end else begin
      raddr = '0;
    end
  end

  olad_ram #(
    .Width (olad_pkg::ValueW),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q  <= cmd_i.out_elem ? rdata : '0;
      out_has_q    <= cmd_i.out_elem;
      out_cnt_q    <= olad_pkg::OutCntW'(len_d);
      out_status_q <= cmd_i.out_status;
      out_last_q   <= cmd_i.out_last;
    end
  end

  // Status back to the controller
  assign stat_o.op         = op_q;
  assign stat_o.full       = (len_q == CntW'(Depth));
  assign stat_o.bad_pos    = (pos_q == '0) || (pos_q > olad_pkg::PosW'(len_q));
  assign stat_o.empty      = (len_q == '0);
  assign stat_o.shift_more = (idx_nx < len_q);
  assign stat_o.rd_last    = (idx_nx == len_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign element_value_o = out_value_q;
  assign has_value_o     = out_has_q;
  assign element_count_o = out_cnt_q;
  assign status_o        = out_status_q;
  assign last_o          = out_last_q;

endmodule

@@ sv/ordered_list_append_delete_at_unit.sv @@
// Append, count, a refused delete and an empty read-out load their result in S_EXEC once the output is free.
// Delete at position p: S_EXEC fetches entry p, then S_SHIFT moves count - p entries, one per cycle through the RAM.
// Read-out: S_EXEC fetches the head, then S_READ emits one element per cycle from the RAM while the output is free.
// One item in work at a time: ready again the cycle after its last result is loaded;
// a stalled output holds off that load; the result register frees the input side early.
// Reset (rst_ni low, asynchronous) empties the list; entry storage is not cleared.
module ordered_list_append_delete_at_unit #(
  parameter int Depth = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      opcode_i,
  input  logic signed [olad_pkg::ValueW-1:0] item_value_i,
  input  logic [olad_pkg::PosW-1:0]       position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [olad_pkg::ValueW-1:0] element_value_o,
  output logic                            has_value_o,
  output logic [olad_pkg::OutCntW-1:0]    element_count_o,
  output logic [1:0]                      status_o,
  output logic                            last_o
);

  olad_pkg::cmd_t  cmd;
  olad_pkg::stat_t stat;

  olad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  olad_dp #(
    .Depth (Depth)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .item_value_i    (item_value_i),
    .position_i      (position_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .element_value_o (element_value_o),
    .has_value_o     (has_value_o),
    .element_count_o (element_count_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

`ifndef ASSERT_OFF
  // Non-element results always close their item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_value_o |-> last_o)
    else $error("non-element result without last");

  // Elements only come from a read-out, which never fails
  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_value_o |-> status_o == olad_pkg::ST_OK)
    else $error("element result with error status");

  // A full refusal reports a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == olad_pkg::ST_FULL |->
      element_count_o == olad_pkg::OutCntW'(Depth))
    else $error("full status with wrong count");

  // The block is busy right after taking an item
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item taken while busy");
`endif

endmodule
